// ===== design/nflp_pkg.sv =====
// shared types, constants and marking table for the nearest field line point unit
package nflp_pkg;

  localparam int NUM_SEGMENTS = 22;
  localparam int FRAC_BITS    = 10;
  localparam int ARC_BITS     = 12;
  localparam int ROOT_BITS    = 17;

  localparam logic [11:0] RADIUS_RESET = 12'd768;

  typedef logic signed [15:0] coord_t;

  localparam coord_t CX0 = coord_t'(1 << FRAC_BITS);
  localparam coord_t CX1 = coord_t'(15 << FRAC_BITS);
  localparam coord_t CY  = coord_t'(1 << FRAC_BITS);

  typedef struct packed {
    coord_t xlo;
    coord_t xhi;
    coord_t ylo;
    coord_t yhi;
  } seg_box_t;

  typedef struct packed {
    coord_t      qx;
    coord_t      qy;
    logic [32:0] best;
    coord_t      bx;
    coord_t      by;
  } seg_data_t;

  typedef struct packed {
    logic [31:0]         d2;
    logic [57:0]         tgt;
    logic [ARC_BITS-1:0] lo;
    logic [2*ARC_BITS-1:0] lo2;
    logic                neg;
    logic                ctr;
  } arc_data_t;

  typedef struct packed {
    logic [33:0]          rem;
    logic [ROOT_BITS-1:0] root;
    coord_t               bx;
    coord_t               by;
  } root_data_t;

  // twentieths of a metre to fixed point, halves rounded up
  function automatic coord_t fx20(input int n);
    fx20 = coord_t'(((n << FRAC_BITS) + 10) / 20);
  endfunction

  function automatic seg_box_t mk_box(input int xlo, input int xhi, input int ylo,
                                      input int yhi);
    mk_box = '{xlo: fx20(xlo), xhi: fx20(xhi), ylo: fx20(ylo), yhi: fx20(yhi)};
  endfunction

  localparam seg_box_t SEG_TABLE [NUM_SEGMENTS] = '{
    mk_box(20, 300, 20, 20),    mk_box(20, 300, 220, 220), mk_box(20, 20, 20, 220),
    mk_box(300, 300, 20, 220),  mk_box(5, 5, 96, 144),     mk_box(315, 315, 96, 144),
    mk_box(5, 20, 96, 96),      mk_box(5, 20, 144, 144),   mk_box(300, 315, 96, 96),
    mk_box(300, 315, 144, 144), mk_box(35, 35, 81, 159),   mk_box(285, 285, 81, 159),
    mk_box(20, 35, 81, 81),     mk_box(20, 35, 159, 159),  mk_box(285, 300, 81, 81),
    mk_box(285, 300, 159, 159), mk_box(121, 199, 35, 35),  mk_box(121, 121, 20, 35),
    mk_box(199, 199, 20, 35),   mk_box(91, 229, 65, 65),   mk_box(91, 91, 20, 65),
    mk_box(229, 229, 20, 65)
  };

endpackage

// ===== design/nflp_query_if.sv =====
// request channel carrying one query point
interface nflp_query_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] query_x;
  logic signed [15:0] query_y;
  modport source(output valid, query_x, query_y, input ready);
  modport sink(input valid, query_x, query_y, output ready);
endinterface

// ===== design/nflp_result_if.sv =====
// result channel carrying one nearest point result
interface nflp_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] near_x;
  logic signed [15:0] near_y;
  logic [15:0]        near_dist;
  modport source(output valid, near_x, near_y, near_dist, input ready);
  modport sink(input valid, near_x, near_y, near_dist, output ready);
endinterface

// ===== design/nearest_field_line_point_unit.sv =====
// top level of the nearest field line point unit
//
// query_i takes one request per cycle while no result is held back: a query point in 1/1024 m, signed.
// result_o returns, for each request and in order, the nearest point on the
// field markings (22 line segments and two corner circles) and its rounded
// distance, saturated at 65535.
// cfg_we_i / cfg_wdata_i write the corner circle radius, reset value 768.
// the query walks through a row of candidate cells, one segment or circle
// point per cell, with the arc search (12 bit cells per axis) and the square
// root (17 bit cells) running as further cell rows; a new request can enter
// while earlier ones are still in the rows.
// when the receiver stalls the whole row holds and query_i.ready drops, so
// the finished result stays in the output register; ready returns as soon
// as the result is taken.
// reset clears the valid bits of every stage and reloads the radius.
module nearest_field_line_point_unit import nflp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [11:0]        cfg_wdata_i,
  nflp_query_if.sink         query_i,
  nflp_result_if.source      result_o
);
  localparam int SEG_CELLS = NUM_SEGMENTS + 2;
  localparam int ARC_END   = ARC_BITS + 2;                // stage of last arc cell
  localparam int PT_TAPS   = NUM_SEGMENTS - ARC_END + 1;  // arc point delay taps
  localparam int LAST      = SEG_CELLS + ROOT_BITS + 1;   // output stage

  typedef struct packed {
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } circ_pt_t;

  logic [11:0]      radius_q;
  logic [LAST:0]    vld_q;
  logic             en;

  coord_t           qx_q, qy_q;

  // arc front end, one entry per circle
  logic [31:0]      ax2_q [2];
  logic [31:0]      ay2_q [2];
  logic [27:0]      rax_q [2];
  logic [27:0]      ray_q [2];
  logic             negx_q [2];
  logic             negy_q [2];
  logic             ctr_q [2];
  arc_data_t        arcx [2][ARC_BITS+1];
  arc_data_t        arcy [2][ARC_BITS+1];
  coord_t           arc_px [2];
  coord_t           arc_py [2];
  circ_pt_t         pt_q [PT_TAPS];

  seg_box_t         box_w [SEG_CELLS];
  seg_data_t        seg_w [SEG_CELLS+1];
  root_data_t       root_w [ROOT_BITS+1];

  logic [17:0]      dist_rnd;
  coord_t           nx_q, ny_q;
  logic [15:0]      nd_q;

  // the whole row moves unless a finished result is held back
  assign en            = !vld_q[LAST] || result_o.ready;
  assign query_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
    end else if (cfg_we_i) begin
      radius_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAST-1:0], query_i.valid};
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en) begin
      qx_q <= query_i.query_x;
      qy_q <= query_i.query_y;
    end
  end

  // arc path: offsets from each centre, squares and radius products
  for (genvar c = 0; c < 2; c++) begin : g_circ
    localparam coord_t CX = (c == 0) ? CX0 : CX1;
    logic signed [16:0] dx, dy;
    logic [15:0]        ax, ay;
    logic [16:0]        px_w, py_w;

    always_comb begin
      dx = {qx_q[15], qx_q} - 17'(CX);
      dy = {qy_q[15], qy_q} - 17'(CY);
      ax = dx[16] ? 16'(-dx) : dx[15:0];
      ay = dy[16] ? 16'(-dy) : dy[15:0];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        ax2_q[c]  <= ax * ax;
        ay2_q[c]  <= ay * ay;
        rax_q[c]  <= radius_q * ax;
        ray_q[c]  <= radius_q * ay;
        negx_q[c] <= dx[16];
        negy_q[c] <= dy[16];
        ctr_q[c]  <= (dx == '0) && (dy == '0);
      end
    end

    // second front stage: |p-c|^2 and (2 r a)^2, registered as the row head
    always_ff @(posedge clk_i) begin
      if (en) begin
        arcx[c][0] <= '{d2: ax2_q[c] + ay2_q[c],
                        tgt: {56'(rax_q[c]) * 56'(rax_q[c]), 2'b00},
                        lo: '0, lo2: '0, neg: negx_q[c], ctr: ctr_q[c]};
        arcy[c][0] <= '{d2: ax2_q[c] + ay2_q[c],
                        tgt: {56'(ray_q[c]) * 56'(ray_q[c]), 2'b00},
                        lo: '0, lo2: '0, neg: negy_q[c], ctr: ctr_q[c]};
      end
    end

    for (genvar j = 0; j < ARC_BITS; j++) begin : g_bit
      nflp_arc_cell u_x (
        .clk_i (clk_i), .en_i (en), .bit_i (4'(ARC_BITS - 1 - j)),
        .data_i (arcx[c][j]), .data_o (arcx[c][j+1])
      );
      nflp_arc_cell u_y (
        .clk_i (clk_i), .en_i (en), .bit_i (4'(ARC_BITS - 1 - j)),
        .data_i (arcy[c][j]), .data_o (arcy[c][j+1])
      );
    end

    // query at the centre takes angle 0 toward the field interior
    always_comb begin
      if (arcx[c][ARC_BITS].ctr) begin
        px_w = (c == 0) ? 17'(CX) + 17'(radius_q) : 17'(CX) - 17'(radius_q);
        py_w = 17'(CY);
      end else begin
        px_w = arcx[c][ARC_BITS].neg ? 17'(CX) - 17'(arcx[c][ARC_BITS].lo)
                                     : 17'(CX) + 17'(arcx[c][ARC_BITS].lo);
        py_w = arcy[c][ARC_BITS].neg ? 17'(CY) - 17'(arcy[c][ARC_BITS].lo)
                                     : 17'(CY) + 17'(arcy[c][ARC_BITS].lo);
      end
      arc_px[c] = px_w[15:0];
      arc_py[c] = py_w[15:0];
    end
  end

  // arc points wait here until the segment row catches up
  always_ff @(posedge clk_i) begin
    if (en) begin
      pt_q[0] <= '{x0: arc_px[0], y0: arc_py[0], x1: arc_px[1], y1: arc_py[1]};
      for (int k = 1; k < PT_TAPS; k++) pt_q[k] <= pt_q[k-1];
    end
  end

  // candidate row: segments first, then the two circle points as degenerate boxes
  always_comb begin
    for (int i = 0; i < NUM_SEGMENTS; i++) box_w[i] = SEG_TABLE[i];
    box_w[NUM_SEGMENTS]   = '{xlo: pt_q[PT_TAPS-2].x0, xhi: pt_q[PT_TAPS-2].x0,
                              ylo: pt_q[PT_TAPS-2].y0, yhi: pt_q[PT_TAPS-2].y0};
    box_w[NUM_SEGMENTS+1] = '{xlo: pt_q[PT_TAPS-1].x1, xhi: pt_q[PT_TAPS-1].x1,
                              ylo: pt_q[PT_TAPS-1].y1, yhi: pt_q[PT_TAPS-1].y1};
  end

  assign seg_w[0] = '{qx: qx_q, qy: qy_q, best: '1, bx: '0, by: '0};

  for (genvar i = 0; i < SEG_CELLS; i++) begin : g_seg
    nflp_seg_cell u_cell (
      .clk_i (clk_i), .en_i (en), .box_i (box_w[i]),
      .data_i (seg_w[i]), .data_o (seg_w[i+1])
    );
  end

  // square root row
  assign root_w[0] = '{rem: {1'b0, seg_w[SEG_CELLS].best}, root: '0,
                       bx: seg_w[SEG_CELLS].bx, by: seg_w[SEG_CELLS].by};

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
    nflp_root_cell u_cell (
      .clk_i (clk_i), .en_i (en), .bit_i (5'(ROOT_BITS - 1 - k)),
      .data_i (root_w[k]), .data_o (root_w[k+1])
    );
  end

  // round to nearest and saturate
  assign dist_rnd = 18'(root_w[ROOT_BITS].root)
                  + 18'(root_w[ROOT_BITS].rem > 34'(root_w[ROOT_BITS].root));

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= root_w[ROOT_BITS].bx;
      ny_q <= root_w[ROOT_BITS].by;
      nd_q <= (dist_rnd > 18'd65535) ? 16'hffff : dist_rnd[15:0];
    end
  end

  assign result_o.valid     = vld_q[LAST];
  assign result_o.near_x    = nx_q;
  assign result_o.near_y    = ny_q;
  assign result_o.near_dist = nd_q;

  // an accepted request enters the first stage
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (query_i.valid && query_i.ready) |=> vld_q[0])
    else $error("accepted request not in first stage");

  // a held result freezes every stage
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=> $stable(vld_q))
    else $error("stages moved during stall");

  // a new result only comes from the stage before it
  a_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(vld_q[LAST]) |-> $past(vld_q[LAST-1]))
    else $error("result valid without a source");
endmodule

// ===== design/nflp_seg_cell.sv =====
// one candidate cell: clamp onto a box, compare squared distance, keep the best
module nflp_seg_cell import nflp_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  seg_box_t  box_i,
  input  seg_data_t data_i,
  output seg_data_t data_o
);
  coord_t             px, py;
  logic signed [16:0] dx, dy;
  logic [15:0]        ax, ay;
  logic [31:0]        sx, sy;
  logic [32:0]        d2;
  seg_data_t          data_d, data_q;

  always_comb begin
    if (data_i.qx < box_i.xlo) px = box_i.xlo;
    else if (data_i.qx > box_i.xhi) px = box_i.xhi;
    else px = data_i.qx;
    if (data_i.qy < box_i.ylo) py = box_i.ylo;
    else if (data_i.qy > box_i.yhi) py = box_i.yhi;
    else py = data_i.qy;
    dx = {data_i.qx[15], data_i.qx} - {px[15], px};
    dy = {data_i.qy[15], data_i.qy} - {py[15], py};
    ax = dx[16] ? 16'(-dx) : dx[15:0];
    ay = dy[16] ? 16'(-dy) : dy[15:0];
    sx = ax * ax;
    sy = ay * ay;
    d2 = {1'b0, sx} + {1'b0, sy};
    data_d = data_i;
    // strict compare keeps the lower index on ties
    if (d2 < data_i.best) begin
      data_d.best = d2;
      data_d.bx   = px;
      data_d.by   = py;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

// ===== design/nflp_arc_cell.sv =====
// one bit of the arc offset search: largest o with (2o-1)^2 d2 <= tgt
module nflp_arc_cell import nflp_pkg::*; (
  input  logic      clk_i,
  input  logic      en_i,
  input  logic [3:0] bit_i,
  input  arc_data_t data_i,
  output arc_data_t data_o
);
  logic [ARC_BITS-1:0]   c;
  logic [2*ARC_BITS-1:0] c2;
  logic [25:0]           t2;
  logic [57:0]           prod;
  arc_data_t             data_d, data_q;

  always_comb begin
    c  = data_i.lo | (ARC_BITS'(1) << bit_i);
    // c^2 built from lo^2 by shifts only
    c2 = data_i.lo2 + (24'(data_i.lo) << ({1'b0, bit_i} + 5'd1))
         + (24'(1) << {bit_i, 1'b0});
    t2 = {c2, 2'b00} - 26'({c, 2'b00}) + 26'd1;
    prod = 58'(t2) * 58'(data_i.d2);
    data_d = data_i;
    if (prod <= data_i.tgt) begin
      data_d.lo  = c;
      data_d.lo2 = c2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule

// ===== design/nflp_root_cell.sv =====
// one bit of the integer square root of the best squared distance
module nflp_root_cell import nflp_pkg::*; (
  input  logic       clk_i,
  input  logic       en_i,
  input  logic [4:0] bit_i,
  input  root_data_t data_i,
  output root_data_t data_o
);
  logic [34:0] inc;
  root_data_t  data_d, data_q;

  always_comb begin
    inc = (35'(data_i.root) << (6'(bit_i) + 6'd1)) + (35'(1) << {bit_i, 1'b0});
    data_d = data_i;
    if ({1'b0, data_i.rem} >= inc) begin
      data_d.rem  = data_i.rem - inc[33:0];
      data_d.root = data_i.root | (ROOT_BITS'(1) << bit_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) data_q <= data_d;
  end

  assign data_o = data_q;
endmodule
